[hdl/mdd_pkg.sv]
// Shared types and constants of the motion dwell detector.
package mdd_pkg;

  // Countdown width and field widths
  localparam int unsigned TimerWidth = 16;
  localparam int unsigned RegWidth   = 16;
  localparam int unsigned CountWidth = 8;
  localparam int unsigned IdxWidth   = 3;

  // Reset values of the configuration registers
  localparam logic                  EnableRst    = 1'b0;
  localparam logic [CountWidth-1:0] ThresholdRst = 8'd3;
  localparam logic [RegWidth-1:0]   ReadyRst     = 16'd3000;
  localparam logic [RegWidth-1:0]   SpaceRst     = 16'd1000;
  localparam logic [RegWidth-1:0]   ClearRst     = 16'd2000;

  // Command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_CHECK = 2'd1,
    CMD_START = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  // Configuration register indexes
  typedef enum logic [IdxWidth-1:0] {
    REG_ENABLE    = 3'd0,
    REG_THRESHOLD = 3'd1,
    REG_READY     = 3'd2,
    REG_SPACE     = 3'd3,
    REG_CLEAR     = 3'd4
  } reg_idx_e;

  // Current configuration
  typedef struct packed {
    logic                  enable;
    logic [CountWidth-1:0] threshold;
    logic [RegWidth-1:0]   ready_time;
    logic [RegWidth-1:0]   space_time;
    logic [RegWidth-1:0]   clear_time;
  } cfg_t;

  // One input item
  typedef struct packed {
    logic sensor_level;
    cmd_e command;
  } item_t;

  // One result item
  typedef struct packed {
    logic [CountWidth-1:0] detect_count;
    logic                  dwell_warning;
    logic                  detect_pulse;
  } res_t;

endpackage

[hdl/mdd_cfg.sv]
// Configuration register file of the motion dwell detector.
module mdd_cfg (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [mdd_pkg::IdxWidth-1:0]    cfg_idx_i,
  input  logic [mdd_pkg::RegWidth-1:0]    cfg_wdata_i,
  output mdd_pkg::cfg_t                   cfg_o
);

  mdd_pkg::cfg_t cfg_q, cfg_d;

  // Decode the write; ignore indexes past the last register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (mdd_pkg::reg_idx_e'(cfg_idx_i))
        mdd_pkg::REG_ENABLE:    cfg_d.enable     = cfg_wdata_i[0];
        mdd_pkg::REG_THRESHOLD: cfg_d.threshold  = cfg_wdata_i[mdd_pkg::CountWidth-1:0];
        mdd_pkg::REG_READY:     cfg_d.ready_time = cfg_wdata_i;
        mdd_pkg::REG_SPACE:     cfg_d.space_time = cfg_wdata_i;
        mdd_pkg::REG_CLEAR:     cfg_d.clear_time = cfg_wdata_i;
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable     <= mdd_pkg::EnableRst;
      cfg_q.threshold  <= mdd_pkg::ThresholdRst;
      cfg_q.ready_time <= mdd_pkg::ReadyRst;
      cfg_q.space_time <= mdd_pkg::SpaceRst;
      cfg_q.clear_time <= mdd_pkg::ClearRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hdl/mdd_core.sv]
// Countdown timers, motion latch and detection counter with the per-item update.
module mdd_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          step_i,
  input  mdd_pkg::item_t item_i,
  input  mdd_pkg::cfg_t  cfg_i,
  output mdd_pkg::res_t  res_o
);

  localparam int unsigned TW = mdd_pkg::TimerWidth;
  localparam int unsigned CW = mdd_pkg::CountWidth;

  logic [TW-1:0] ready_q, ready_d;
  logic [TW-1:0] space_q, space_d;
  logic [TW-1:0] clear_q, clear_d;
  logic          latch_q, latch_d;
  logic [CW-1:0] det_q, det_d;

  logic [TW-1:0] ready_rld, space_rld, clear_rld;
  logic [CW-1:0] det_inc;
  logic          pulse, warn;

  assign ready_rld = TW'(cfg_i.ready_time);
  assign space_rld = TW'(cfg_i.space_time);
  assign clear_rld = TW'(cfg_i.clear_time);

  // Work out the next state and the flags for the item in hand
  always_comb begin
    ready_d = ready_q;
    space_d = space_q;
    clear_d = clear_q;
    latch_d = latch_q;
    det_d   = det_q;
    det_inc = '0;
    pulse   = 1'b0;
    warn    = 1'b0;
    case (item_i.command)
      mdd_pkg::CMD_TICK: begin
        if (ready_q != '0) ready_d = ready_q - TW'(1);
        if (space_q != '0) space_d = space_q - TW'(1);
        if (clear_q != '0) clear_d = clear_q - TW'(1);
      end
      mdd_pkg::CMD_START: begin
        ready_d = ready_rld;
        space_d = space_rld;
      end
      mdd_pkg::CMD_CHECK: begin
        if (cfg_i.enable) begin
          // clear rule: rearm on motion, drop the count on quiet
          if (clear_q == '0 && latch_q) begin
            if (item_i.sensor_level) begin
              clear_d = clear_rld;
            end else begin
              latch_d = 1'b0;
              det_d   = '0;
            end
          end
          // count a detection once ready and spacing have run out
          if (space_q == '0 && ready_q == '0 && item_i.sensor_level) begin
            det_inc = det_d + CW'(1);
            latch_d = 1'b1;
            clear_d = clear_rld;
            space_d = space_rld;
            pulse   = 1'b1;
            if (det_inc >= cfg_i.threshold) begin
              warn  = 1'b1;
              det_d = '0;
            end else begin
              det_d = det_inc;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // Commit the state when the item moves to the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= TW'(mdd_pkg::ReadyRst);
      space_q <= TW'(mdd_pkg::SpaceRst);
      clear_q <= '0;
      latch_q <= 1'b0;
      det_q   <= '0;
    end else if (step_i) begin
      ready_q <= ready_d;
      space_q <= space_d;
      clear_q <= clear_d;
      latch_q <= latch_d;
      det_q   <= det_d;
    end
  end

  assign res_o.detect_pulse  = pulse;
  assign res_o.dwell_warning = warn;
  assign res_o.detect_count  = det_d;

endmodule

[hdl/motion_dwell_detector.sv]
// Top level of the motion dwell detector: stream ports, input and result registers.
//
// Usage: items enter on the s_axis channel; each carries a command (tick, check,
// start) and the sensor level. For every item exactly one result leaves on the
// m_axis channel, in order: detect pulse, dwell warning and the detection count.
// Thresholds and times are set through the write port (cfg_we_i, cfg_idx_i,
// cfg_wdata_i) while no item is in flight.
// Flow: an accepted item waits in the input register until the result register
// frees up; its result is then loaded into the result register and m_axis_tvalid
// rises. Throughput: one item per cycle while m_axis_tready stays high; the single
// update of the timers and counter between the two registers sets that figure.
// Reset: ready and space timers load their reset reload values, clear timer, latch
// and count clear, both registers empty, configuration takes its reset values.
// Stall: while m_axis_tready is low the result holds; an empty input register still
// takes one more item, after which s_axis_tready drops until the result is taken.
module motion_dwell_detector (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [7:0]                   s_axis_tdata,   // [1:0] command, [2] sensor_level
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [15:0]                  m_axis_tdata,   // [0] detect_pulse,
                                                       // [1] dwell_warning, [9:2] detect_count
  input  logic                         cfg_we_i,
  input  logic [mdd_pkg::IdxWidth-1:0] cfg_idx_i,
  input  logic [mdd_pkg::RegWidth-1:0] cfg_wdata_i
);

  mdd_pkg::cfg_t  cfg;
  mdd_pkg::item_t in_q;
  logic           in_vld_q;
  mdd_pkg::res_t  res;
  mdd_pkg::res_t  out_q;
  logic           out_vld_q;
  logic           advance, step;

  mdd_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // The result register frees up when empty or being taken
  assign advance       = !out_vld_q || m_axis_tready;
  assign step          = in_vld_q && advance;
  assign s_axis_tready = !in_vld_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_vld_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_q.command      <= mdd_pkg::cmd_e'(s_axis_tdata[1:0]);
      in_q.sensor_level <= s_axis_tdata[2];
    end
  end

  mdd_core u_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(in_q),
    .cfg_i (cfg),
    .res_o (res)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {6'b0, out_q.detect_count, out_q.dwell_warning, out_q.detect_pulse};

endmodule

[hdl/mdd_checker.sv]
// Port-level checks of the motion dwell detector, bound to the top level.
module mdd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);

  // Hold a stalled result
  a_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

  // A warning only comes with a counted detection
  a_warn_pulse : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[0])
    else $error("warning without detection");

  // A warning restarts the count
  a_warn_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |-> m_axis_tdata[9:2] == 8'd0)
    else $error("count not restarted on warning");

  // With the result register full and stalled, the input side takes at most one more item
  a_backpressure : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready && s_axis_tvalid && s_axis_tready
    && !m_axis_tready |=> !m_axis_tready |-> !s_axis_tready)
    else $error("input taken past a full pipeline");

  // Padding bits of the result stay zero
  a_pad : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
    else $error("result padding not zero");

endmodule

bind motion_dwell_detector mdd_checker u_mdd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
